FILE: src/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORDS = 16;
  localparam int ROUNDS = 64;
  localparam int LEN_OFFSET = 56;
  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Requests from the byte sequencer to the compression core
  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic       start;
    logic       init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

FILE: src/sha256_message_hasher.sv
`timescale 1ns / 1ps

// SHA-256 over a byte stream.
// Input channel s_*: one request per byte. s_tuser set means s_tdata holds a
// message byte; s_tlast ends the message (with or without a byte).
// Output channel m_*: one digest per message, digest_word0 in the lowest bits.
// Bytes are taken at one per cycle while s_tready is high, into a 16-word
// block store. Each full block runs through one shared round unit at one
// round per cycle: 64 rounds, then a fold into the chain, during which
// s_tready is low.
// On the last request the sequencer writes padding one byte per cycle,
// then compresses one or two more blocks before the digest appears.
// s_tready stays low while the digest waits; a stall on m_tready just holds
// the digest. Once taken, the chain returns to the initial hash values.
// Reset clears the byte count and the bit count, loads the chain with the
// initial hash values, and leaves the block ready for a new message.

module sha256_message_hasher (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // byte_valid
  input  logic         s_tlast,   // last_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata    // digest_word0 .. digest_word7, 32 bits each
);
  import sha_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_BLK, S_PAD, S_PADBLK, S_OUT} state_t;

  state_t     state;
  logic [5:0] fill;
  logic [63:0] bits;
  logic [5:0] pos;
  logic       marked;
  logic       len_flag;
  logic       pend_last;

  core_ctrl_t ctrl;
  core_stat_t stat;
  logic       in_acc;
  logic [7:0] pad_byte;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);

  always_comb begin
    if (!marked)                                  pad_byte = PAD_MARK;
    else if (len_flag && pos >= 6'(LEN_OFFSET))   pad_byte = bits[63:56];
    else                                          pad_byte = '0;
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      S_IDLE: begin
        ctrl.wr_en   = in_acc && s_tuser;
        ctrl.wr_pos  = fill;
        ctrl.wr_byte = s_tdata;
        ctrl.start   = in_acc && s_tuser && (fill == 6'(BLOCK_BYTES - 1));
      end
      S_PAD: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_pos  = pos;
        ctrl.wr_byte = pad_byte;
        ctrl.start   = (pos == 6'(BLOCK_BYTES - 1));
      end
      S_OUT:   ctrl.init = m_tready;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      bits      <= '0;
      pos       <= '0;
      marked    <= 1'b0;
      len_flag  <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            pend_last <= s_tlast;
            marked    <= 1'b0;
            if (s_tuser) begin
              fill <= fill + 6'd1;
              bits <= bits + 64'd8;
              if (fill == 6'(BLOCK_BYTES - 1)) begin
                state <= S_BLK;
              end else if (s_tlast) begin
                pos      <= fill + 6'd1;
                len_flag <= (fill + 6'd1) < 6'(LEN_OFFSET);
                state    <= S_PAD;
              end
            end else if (s_tlast) begin
              pos      <= fill;
              len_flag <= fill < 6'(LEN_OFFSET);
              state    <= S_PAD;
            end
          end
        end
        S_BLK: begin
          if (stat.done) begin
            if (pend_last) begin
              pos      <= '0;
              len_flag <= 1'b1;
              state    <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PAD: begin
          marked <= 1'b1;
          pos    <= pos + 6'd1;
          // shift out the big-endian length one byte at a time
          if (marked && len_flag && pos >= 6'(LEN_OFFSET)) bits <= bits << 8;
          if (pos == 6'(BLOCK_BYTES - 1)) state <= S_PADBLK;
        end
        S_PADBLK: begin
          if (stat.done) begin
            if (len_flag) begin
              state <= S_OUT;
            end else begin
              pos      <= '0;
              len_flag <= 1'b1;
              state    <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            fill  <= '0;
            bits  <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .chain_flat (m_tdata)
  );

  a_no_input_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input accepted while digest pending");

  a_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr_en || ctrl.start) |-> !stat.busy)
    else $error("block store written while core busy");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> (fill == '0 && bits == '0 && !stat.busy))
    else $error("counters not cleared after digest");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == S_BLK || state == S_PADBLK))
    else $error("compression finished outside a wait state");

endmodule

FILE: src/sha_core.sv
`timescale 1ns / 1ps

module sha_core (
  input  logic               clk,
  input  logic               rst,
  input  sha_pkg::core_ctrl_t ctrl,
  output sha_pkg::core_stat_t stat,
  output logic [255:0]       chain_flat
);
  import sha_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_FOLD} cstate_t;

  cstate_t     state;
  logic [5:0]  rnd;
  logic [31:0] w [WORDS];
  logic [31:0] v [8];
  logic [31:0] chain [8];

  logic [31:0] big0, big1, choose, major, t1, t2, s0, s1, w_new;

  always_comb begin
    big1   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
             {v[4][24:0], v[4][31:25]};
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big1 + choose + ROUND_K[rnd] + w[0];
    big0   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
             {v[0][21:0], v[0][31:22]};
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big0 + major;
    s0     = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1     = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^
             (w[14] >> 10);
    w_new  = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
    end else begin
      unique case (state)
        C_IDLE: begin
          if (ctrl.init) begin
            for (int i = 0; i < 8; i++) chain[i] <= INIT_HASH[i];
          end
          if (ctrl.start) begin
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == 6'(ROUNDS - 1)) state <= C_FOLD;
        end
        C_FOLD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // Message words: byte writes while idle, schedule shift during rounds
  always_ff @(posedge clk) begin
    if (state == C_ROUND) begin
      for (int i = 0; i < WORDS - 1; i++) w[i] <= w[i + 1];
      w[WORDS - 1] <= w_new;
    end else if (ctrl.wr_en) begin
      w[ctrl.wr_pos[5:2]][{~ctrl.wr_pos[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
    end
  end

  assign stat.busy = (state != C_IDLE);
  assign stat.done = (state == C_FOLD);

  always_comb begin
    for (int i = 0; i < 8; i++) chain_flat[32 * i +: 32] = chain[i];
  end

endmodule
